FILE: hw/rtl/bmhq_pkg.sv
package bmhq_pkg;

  // Heap geometry. Slots 1..CAPACITY hold entries, slot 0 is never used.
  localparam int unsigned CAPACITY = 255;
  localparam int unsigned DEPTH    = CAPACITY + 1;
  localparam int unsigned IDX_W    = $clog2(DEPTH);
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned COUNT_W  = 8;

  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [IDX_W:0]          cidx_t;  // child / scan index, one bit of headroom
  typedef logic signed [KEY_W-1:0] key_t;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_FIND   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0] cmd;
    key_t       key;
  } item_t;

  typedef struct packed {
    status_e              status;
    key_t                 result_key;
    logic [COUNT_W-1:0]   count;
  } result_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_INS_INIT,
    OP_INS_RD,
    OP_INS_MOVE,
    OP_INS_PUT,
    OP_DEL_INIT,
    OP_DEL_LOAD,
    OP_DEL_RD,
    OP_DEL_MOVE,
    OP_DEL_PUT,
    OP_FIND_INIT,
    OP_FIND_RD,
    OP_FIND_NEXT
  } dp_op_e;

  typedef enum logic [1:0] {
    KSEL_ZERO,
    KSEL_TOP,
    KSEL_SEARCH
  } ksel_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_CHK,
    S_INS_CMP,
    S_DEL_LOAD,
    S_DEL_CHK,
    S_DEL_CMP,
    S_FIND_CHK,
    S_FIND_CMP
  } state_e;

  // Controller -> datapath
  typedef struct packed {
    dp_op_e  op;
    logic    fin;     // publish a result this cycle
    status_e status;
    ksel_e   ksel;
  } dp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic full;
    logic empty;
    logic at_root;
    logic beyond_cnt;  // child / scan index past the last entry
    logic ins_up;      // insert key beats its parent
    logic del_down;    // larger child beats the moved entry
    logic match;       // scanned entry equals the search key
  } dp_sts_t;

endpackage

FILE: hw/rtl/bmhq_ctrl.sv
module bmhq_ctrl
  import bmhq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  logic [1:0] cmd_i,
  input  dp_sts_t    sts_i,
  output logic       busy,
  output dp_cmd_t    dp_cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          unique case (cmd_i)
            CMD_INSERT: state_d = sts_i.full  ? S_IDLE : S_INS_CHK;
            CMD_DELETE: state_d = sts_i.empty ? S_IDLE : S_DEL_LOAD;
            CMD_FIND:   state_d = S_FIND_CHK;
            default:    state_d = S_IDLE;
          endcase
        end
      end
      S_INS_CHK:  state_d = sts_i.at_root    ? S_IDLE : S_INS_CMP;
      S_INS_CMP:  state_d = sts_i.ins_up     ? S_INS_CHK : S_IDLE;
      S_DEL_LOAD: state_d = S_DEL_CHK;
      S_DEL_CHK:  state_d = sts_i.beyond_cnt ? S_IDLE : S_DEL_CMP;
      S_DEL_CMP:  state_d = sts_i.del_down   ? S_DEL_CHK : S_IDLE;
      S_FIND_CHK: state_d = sts_i.beyond_cnt ? S_IDLE : S_FIND_CMP;
      S_FIND_CMP: state_d = sts_i.match      ? S_IDLE : S_FIND_CHK;
      default:    state_d = S_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    dp_cmd_o        = '0;
    dp_cmd_o.op     = OP_NONE;
    dp_cmd_o.status = ST_OK;
    dp_cmd_o.ksel   = KSEL_ZERO;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          unique case (cmd_i)
            CMD_INSERT: begin
              if (sts_i.full) begin
                dp_cmd_o.fin    = 1'b1;
                dp_cmd_o.status = ST_FULL;
              end else begin
                dp_cmd_o.op = OP_INS_INIT;
              end
            end
            CMD_DELETE: begin
              if (sts_i.empty) begin
                dp_cmd_o.fin    = 1'b1;
                dp_cmd_o.status = ST_EMPTY;
              end else begin
                dp_cmd_o.op = OP_DEL_INIT;
              end
            end
            CMD_FIND: dp_cmd_o.op = OP_FIND_INIT;
            default:  dp_cmd_o.fin = 1'b1;  // unused code: plain ok, nothing stored
          endcase
        end
      end
      S_INS_CHK: begin
        if (sts_i.at_root) begin
          dp_cmd_o.op  = OP_INS_PUT;
          dp_cmd_o.fin = 1'b1;
        end else begin
          dp_cmd_o.op = OP_INS_RD;
        end
      end
      S_INS_CMP: begin
        if (sts_i.ins_up) begin
          dp_cmd_o.op = OP_INS_MOVE;
        end else begin
          dp_cmd_o.op  = OP_INS_PUT;
          dp_cmd_o.fin = 1'b1;
        end
      end
      S_DEL_LOAD: dp_cmd_o.op = OP_DEL_LOAD;
      S_DEL_CHK: begin
        if (sts_i.beyond_cnt) begin
          dp_cmd_o.op   = OP_DEL_PUT;
          dp_cmd_o.fin  = 1'b1;
          dp_cmd_o.ksel = KSEL_TOP;
        end else begin
          dp_cmd_o.op = OP_DEL_RD;
        end
      end
      S_DEL_CMP: begin
        if (sts_i.del_down) begin
          dp_cmd_o.op = OP_DEL_MOVE;
        end else begin
          dp_cmd_o.op   = OP_DEL_PUT;
          dp_cmd_o.fin  = 1'b1;
          dp_cmd_o.ksel = KSEL_TOP;
        end
      end
      S_FIND_CHK: begin
        if (sts_i.beyond_cnt) begin
          dp_cmd_o.fin    = 1'b1;
          dp_cmd_o.status = ST_NOT_FOUND;
        end else begin
          dp_cmd_o.op = OP_FIND_RD;
        end
      end
      S_FIND_CMP: begin
        if (sts_i.match) begin
          dp_cmd_o.fin  = 1'b1;
          dp_cmd_o.ksel = KSEL_SEARCH;
        end else begin
          dp_cmd_o.op = OP_FIND_NEXT;
        end
      end
      default: dp_cmd_o.op = OP_NONE;
    endcase
  end

endmodule

FILE: hw/rtl/bmhq_dp.sv
module bmhq_dp
  import bmhq_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  key_t    key_i,
  input  dp_cmd_t dp_cmd_i,
  output dp_sts_t sts_o,
  output result_t result_o,
  output logic    done_o
);

  key_t    heap_mem_q [DEPTH];
  key_t    rd0_q, rd1_q;
  key_t    key_q, top_q;
  idx_t    cnt_q, cnt_d;
  idx_t    pos_q, pos_d;
  cidx_t   child_q, child_d;
  key_t    key_d, top_d;
  result_t res_q, res_d;
  logic    done_q;

  logic    we, re0, re1;
  idx_t    waddr, raddr0, raddr1;
  key_t    wdata;

  idx_t    child_lo;
  logic    take_right;
  idx_t    big_idx;
  key_t    big_val;

  assign child_lo   = child_q[IDX_W-1:0];
  assign take_right = (child_q < {1'b0, cnt_q}) && (rd1_q > rd0_q);
  assign big_idx    = take_right ? IDX_W'(child_lo + 1'b1) : child_lo;
  assign big_val    = take_right ? rd1_q : rd0_q;

  assign sts_o.full       = (cnt_q >= IDX_W'(CAPACITY));
  assign sts_o.empty      = (cnt_q == '0);
  assign sts_o.at_root    = (pos_q == IDX_W'(1));
  assign sts_o.beyond_cnt = (child_q > {1'b0, cnt_q});
  assign sts_o.ins_up     = (key_q > rd0_q);
  assign sts_o.del_down   = (big_val > key_q);
  assign sts_o.match      = (rd0_q == key_q);

  always_comb begin
    we      = 1'b0;
    re0     = 1'b0;
    re1     = 1'b0;
    waddr   = pos_q;
    wdata   = key_q;
    raddr0  = child_lo;
    raddr1  = IDX_W'(child_lo + 1'b1);
    cnt_d   = cnt_q;
    pos_d   = pos_q;
    child_d = child_q;
    key_d   = key_q;
    top_d   = top_q;
    unique case (dp_cmd_i.op)
      OP_NONE: ;
      OP_INS_INIT: begin
        cnt_d = IDX_W'(cnt_q + 1'b1);
        pos_d = IDX_W'(cnt_q + 1'b1);
        key_d = key_i;
      end
      OP_INS_RD: begin
        re0    = 1'b1;
        raddr0 = pos_q >> 1;
      end
      OP_INS_MOVE: begin
        we    = 1'b1;
        wdata = rd0_q;
        pos_d = pos_q >> 1;
      end
      OP_INS_PUT, OP_DEL_PUT: we = 1'b1;
      OP_DEL_INIT: begin
        re0    = 1'b1;
        re1    = 1'b1;
        raddr0 = IDX_W'(1);
        raddr1 = cnt_q;
      end
      OP_DEL_LOAD: begin
        top_d   = rd0_q;
        key_d   = rd1_q;
        cnt_d   = IDX_W'(cnt_q - 1'b1);
        pos_d   = IDX_W'(1);
        child_d = (IDX_W+1)'(2);
      end
      OP_DEL_RD: begin
        re0 = 1'b1;
        re1 = 1'b1;
      end
      OP_DEL_MOVE: begin
        we      = 1'b1;
        wdata   = big_val;
        pos_d   = big_idx;
        child_d = {big_idx, 1'b0};
      end
      OP_FIND_INIT: begin
        key_d   = key_i;
        child_d = (IDX_W+1)'(1);
      end
      OP_FIND_RD:   re0 = 1'b1;
      OP_FIND_NEXT: child_d = (IDX_W+1)'(child_q + 1'b1);
      default: ;
    endcase
  end

  always_comb begin
    res_d.status = dp_cmd_i.status;
    res_d.count  = COUNT_W'(cnt_q);
    case (dp_cmd_i.ksel)
      KSEL_TOP:    res_d.result_key = top_q;
      KSEL_SEARCH: res_d.result_key = key_q;
      default:     res_d.result_key = '0;
    endcase
  end

  // heap store: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (we) begin
      heap_mem_q[waddr] <= wdata;
    end
    if (re0) begin
      rd0_q <= heap_mem_q[raddr0];
    end
    if (re1) begin
      rd1_q <= heap_mem_q[raddr1];
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    child_q <= child_d;
    key_q   <= key_d;
    top_q   <= top_d;
    if (dp_cmd_i.fin) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= dp_cmd_i.fin;
    end
  end

  assign result_o = res_q;
  assign done_o   = done_q;

endmodule

FILE: hw/rtl/binary_max_heap_queue_unit.sv
// Max-heap priority queue. A rejected or unused command gets done_o in the cycle after
// it is accepted. Insert sifts the new key up from the last slot and delete sifts the
// last entry down from the root, each moving at most 7 levels; find scans slots from 1
// upwards and stops on a hit or past the last entry. One command at a time, the next
// start is taken in the done_o cycle; results cannot be stalled.
// Reset (rst_ni low, async) empties the queue; the store itself is not cleared.
module binary_max_heap_queue_unit
  import bmhq_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  input  item_t   item_i,
  output logic    done_o,
  output result_t result_o
);

  // Controller <-> datapath handshake. The controller only sees condensed
  // status flags; the datapath owns the heap RAM, the entry count and all
  // index / key registers.
  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  // Sequencer: one state per half-step of a sift (read issue, then compare
  // and write), plus a check/compare state loop for the linear find.
  bmhq_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .cmd_i    (item_i.cmd),
    .sts_i    (dp_sts),
    .busy     (busy),
    .dp_cmd_o (dp_cmd)
  );

  // Datapath: heap RAM (1W/2R, registered reads), count, sift indexes, and the
  // result register, held until the next result; done_o is a one-cycle strobe.
  bmhq_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .key_i    (item_i.key),
    .dp_cmd_i (dp_cmd),
    .sts_o    (dp_sts),
    .result_o (result_o),
    .done_o   (done_o)
  );

  // A result beat always lands while the sequencer is back in idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result beat while sequencer busy");

  // Insert into a full queue is answered in the next cycle with full status.
  a_full_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && item_i.cmd == CMD_INSERT && dp_sts.full)
      |=> (done_o && result_o.status == ST_FULL))
    else $error("insert on full queue not rejected");

  // Delete on an empty queue is answered in the next cycle with empty status.
  a_empty_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && item_i.cmd == CMD_DELETE && dp_sts.empty)
      |=> (done_o && result_o.status == ST_EMPTY && result_o.result_key == '0))
    else $error("delete on empty queue not rejected");

  // A miss never returns a key.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.status == ST_NOT_FOUND) |-> (result_o.result_key == '0))
    else $error("find miss returned a nonzero key");

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import bmhq_pkg::*;

  // Command code that the block ignores (no enum member for it).
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam key_t KEY_MIN  = 32'sh8000_0000;
  localparam key_t KEY_MAX  = 32'sh7FFF_FFFF;
  localparam key_t KEY_ONES = 32'shFFFF_FFFF;

  // Random beats that reach the block's logic (ignored commands not counted).
  localparam int unsigned RANDOM_BEATS = 1430;
  // Tail wait after the last result, long enough for a find over a full heap.
  localparam int unsigned DRAIN_CYCLES = 600;

  typedef enum logic [1:0] {
    TRAFFIC_FILL,
    TRAFFIC_DRAIN,
    TRAFFIC_EVEN
  } traffic_e;

  // One row of the directed table. When 'typed' is set, the row carries its
  // own expected result; otherwise the heap predictor supplies it.
  typedef struct {
    logic [1:0]         cmd;
    key_t               key;
    bit                 typed;
    status_e            st;
    key_t               rkey;
    logic [COUNT_W-1:0] cnt;
  } dir_row_t;

  localparam int unsigned DIR_ROWS = 24;

  dir_row_t dir_table [DIR_ROWS] = '{
    // Empty heap: delete and find both refuse, the unused code does nothing.
    '{CMD_DELETE, 32'sd0,          1'b1, ST_EMPTY,     32'sd0,  8'd0},
    '{CMD_FIND,   KEY_MAX,         1'b1, ST_NOT_FOUND, 32'sd0,  8'd0},
    '{CMD_UNUSED, 32'sh5A5A_A5A5,  1'b1, ST_OK,        32'sd0,  8'd0},
    // Extreme keys in, KEY_MIN first so that KEY_MAX sifts up to the root.
    '{CMD_INSERT, KEY_MIN,         1'b1, ST_OK,        32'sd0,  8'd1},
    '{CMD_INSERT, KEY_MAX,         1'b1, ST_OK,        32'sd0,  8'd2},
    '{CMD_INSERT, 32'sd0,          1'b1, ST_OK,        32'sd0,  8'd3},
    '{CMD_INSERT, KEY_ONES,        1'b1, ST_OK,        32'sd0,  8'd4},
    '{CMD_FIND,   KEY_MAX,         1'b1, ST_OK,        KEY_MAX, 8'd4},
    '{CMD_FIND,   KEY_MIN,         1'b1, ST_OK,        KEY_MIN, 8'd4},
    '{CMD_FIND,   32'sd1,          1'b1, ST_NOT_FOUND, 32'sd0,  8'd4},
    '{CMD_UNUSED, KEY_ONES,        1'b1, ST_OK,        32'sd0,  8'd4},
    // Drain in signed order, then underflow once more.
    '{CMD_DELETE, 32'sd0,          1'b1, ST_OK,        KEY_MAX, 8'd3},
    '{CMD_DELETE, KEY_ONES,        1'b1, ST_OK,        32'sd0,  8'd2},
    '{CMD_DELETE, 32'sd0,          1'b1, ST_OK,        KEY_ONES, 8'd1},
    '{CMD_DELETE, KEY_MAX,         1'b1, ST_OK,        KEY_MIN, 8'd0},
    '{CMD_DELETE, 32'sd0,          1'b1, ST_EMPTY,     32'sd0,  8'd0},
    // Duplicate keys: ties on the way up and on the way down.
    '{CMD_INSERT, 32'sd7,          1'b0, ST_OK,        32'sd0,  8'd0},
    '{CMD_INSERT, 32'sd7,          1'b0, ST_OK,        32'sd0,  8'd0},
    '{CMD_INSERT, -32'sd7,         1'b0, ST_OK,        32'sd0,  8'd0},
    '{CMD_INSERT, 32'sd9,          1'b0, ST_OK,        32'sd0,  8'd0},
    '{CMD_FIND,   32'sd7,          1'b0, ST_OK,        32'sd0,  8'd0},
    '{CMD_DELETE, 32'sd0,          1'b0, ST_OK,        32'sd0,  8'd0},
    '{CMD_DELETE, 32'sd0,          1'b0, ST_OK,        32'sd0,  8'd0},
    '{CMD_FIND,   -32'sd7,         1'b0, ST_OK,        32'sd0,  8'd0}
  };

  logic    clk_i;
  logic    rst_ni;
  logic    start;
  logic    busy;
  item_t   item_i;
  logic    done_o;
  result_t result_o;

  binary_max_heap_queue_unit u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .item_i   (item_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

  // 2 ns clock
  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Heap predictor: its own copy of the store and the entry count.
  // ---------------------------------------------------------------------------
  key_t        heap_slots [1:CAPACITY];
  int unsigned held = 0;

  // Results still owed by the block, oldest first.
  result_t     pending_results [$];
  int unsigned mismatches = 0;
  int unsigned burst_left = 0;

  // Apply one command to the predicted heap and return the result it yields.
  function automatic result_t heap_apply(item_t beat);
    result_t     r;
    key_t        k;
    key_t        top;
    key_t        moved;
    int unsigned pos;
    int unsigned kid;
    r = '{status: ST_OK, result_key: '0, count: '0};
    k = beat.key;
    case (beat.cmd)
      CMD_INSERT: begin
        if (held >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          held++;
          pos = held;
          // sift up while strictly greater than the parent
          while (pos != 1 && k > heap_slots[pos / 2]) begin
            heap_slots[pos] = heap_slots[pos / 2];
            pos = pos / 2;
          end
          heap_slots[pos] = k;
        end
      end
      CMD_DELETE: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          top   = heap_slots[1];
          moved = heap_slots[held];
          held--;
          pos = 1;
          kid = 2;
          // sift down: larger child, left one on a tie
          while (kid <= held) begin
            if (kid < held && heap_slots[kid + 1] > heap_slots[kid]) kid++;
            if (!(heap_slots[kid] > moved)) break;
            heap_slots[pos] = heap_slots[kid];
            pos = kid;
            kid = kid * 2;
          end
          heap_slots[pos] = moved;
          r.result_key = top;
        end
      end
      CMD_FIND: begin
        r.status = ST_NOT_FOUND;
        for (int unsigned i = 1; i <= held; i++) begin
          if (heap_slots[i] == k) begin
            r.status     = ST_OK;
            r.result_key = k;
            break;
          end
        end
      end
      default: ;  // unused code: no effect
    endcase
    r.count = held[COUNT_W-1:0];
    return r;
  endfunction

  // Random beat, biased by the traffic mix. Finds hit a stored key half the time.
  function automatic item_t draw_beat(traffic_e mix);
    item_t       b;
    int unsigned roll;
    int unsigned ins_lim;
    int unsigned del_lim;
    roll = $urandom_range(99);
    case (mix)
      TRAFFIC_FILL:  begin ins_lim = 80; del_lim = 88; end
      TRAFFIC_DRAIN: begin ins_lim = 15; del_lim = 85; end
      default:       begin ins_lim = 40; del_lim = 70; end
    endcase
    if (roll < ins_lim)      b.cmd = CMD_INSERT;
    else if (roll < del_lim) b.cmd = CMD_DELETE;
    else if (roll < 97)      b.cmd = CMD_FIND;
    else                     b.cmd = CMD_UNUSED;

    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0:       b.key = KEY_MIN;
          1:       b.key = KEY_MAX;
          2:       b.key = '0;
          default: b.key = KEY_ONES;
        endcase
      end
      1, 2, 3: b.key = key_t'($urandom_range(16)) - 32'sd8;  // narrow range, many ties
      default: b.key = key_t'($urandom);
    endcase
    if (b.cmd == CMD_FIND && held != 0 && $urandom_range(1) == 0)
      b.key = heap_slots[$urandom_range(held, 1)];
    return b;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus side. Inputs move on the falling edge only.
  // ---------------------------------------------------------------------------

  // Park start low for a number of cycles; item_i carries noise meanwhile.
  task automatic hold_off(int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      start  <= 1'b0;
      item_i <= '{cmd: 2'($urandom), key: key_t'($urandom)};
    end
  endtask

  // Bursts of back-to-back beats separated by random gaps.
  task automatic pace();
    if (burst_left == 0) begin
      if ($urandom_range(3) == 0) hold_off($urandom_range(40, 10));
      else                        hold_off($urandom_range(6, 1));
      burst_left = $urandom_range(32, 1);
    end
    burst_left--;
  endtask

  // Present one beat and hold it until accepted (start high, busy low at the
  // rising edge). start stays high afterwards; the next beat or a gap decides.
  // The expectation queued is the typed one if given, else the predictor's.
  task automatic send_beat(item_t beat, bit typed, result_t typed_result);
    result_t predicted;
    @(negedge clk_i);
    start  <= 1'b1;
    item_i <= beat;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predicted = heap_apply(beat);
    pending_results.push_back(typed ? typed_result : predicted);
  endtask

  task automatic report_field(string field, logic [63:0] want, logic [63:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, field, want, got);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: each done_o beat against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result beat %0h", $realtime, result_o);
      end else begin
        want = pending_results.pop_front();
        if (result_o.status !== want.status)
          report_field("status", 64'(want.status), 64'(result_o.status));
        if (result_o.result_key !== want.result_key)
          report_field("result_key", 64'(unsigned'(want.result_key)),
                       64'(unsigned'(result_o.result_key)));
        if (result_o.count !== want.count)
          report_field("count", 64'(want.count), 64'(result_o.count));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : run
    item_t       beat;
    result_t     typed_result;
    traffic_e    mix;
    int unsigned phase_left;
    int unsigned phase_no;
    int unsigned sent;

    rst_ni = 1'b0;
    start  = 1'b0;
    item_i = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table
    foreach (dir_table[i]) begin
      pace();
      beat         = '{cmd: dir_table[i].cmd, key: dir_table[i].key};
      typed_result = '{status: dir_table[i].st, result_key: dir_table[i].rkey,
                       count: dir_table[i].cnt};
      send_beat(beat, dir_table[i].typed, typed_result);
    end

    // Random part: first a long fill that runs into the full heap, then a long
    // drain biased toward deletes, then phases of random mix and length.
    mix        = TRAFFIC_FILL;
    phase_left = 400;
    phase_no   = 0;
    sent       = 0;
    while (sent < RANDOM_BEATS) begin
      if (phase_left == 0) begin
        phase_no++;
        if (phase_no == 1) begin
          mix        = TRAFFIC_DRAIN;
          phase_left = 400;
        end else begin
          mix        = traffic_e'($urandom_range(2));
          phase_left = $urandom_range(250, 30);
        end
      end
      beat = draw_beat(mix);
      pace();
      send_beat(beat, 1'b0, '0);
      if (beat.cmd != CMD_UNUSED) begin
        sent++;
        phase_left--;
      end
    end

    @(negedge clk_i);
    start <= 1'b0;

    // Wait out the last results, then a short tail for stray beats.
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run (every beat a full-heap find).
  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
